/* src/sde_pkg.sv */
// Shared types and constants of the squared distance engine.
`timescale 1ns / 1ps
`default_nettype none

package sde_pkg;

	// Element and arithmetic widths (signed Q8.8 in, unsigned Q26.16 out)
	localparam int ELEM_W   = 16;
	localparam int DIFF_W   = ELEM_W + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int SUM_W    = 43;
	localparam int DIST_W   = 42;
	localparam int VIDX_W   = 16;

	// Configuration
	localparam int DIM_CFG_W = 11;
	localparam logic [DIM_CFG_W-1:0] DIM_RESET = 11'd128;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_DIMENSION_COUNT = 1'b0;

	// Input command codes
	localparam logic CMD_QUERY = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int PEND_W     = 3;

	// Operation carried down the pipeline
	typedef enum logic {
		OP_CLEAR = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	typedef struct packed {
		logic [DIST_W-1:0] sq_dist;
		logic [VIDX_W-1:0] vidx;
	} result_t;

endpackage

`default_nettype wire

/* src/sde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire                                        clk,
	input  wire                                        we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                            wdata,
	input  wire                                        re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/squared_distance_engine.sv */
// Top level of the squared distance engine: APB register, query store and MAC pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Squared Euclidean distance between a stored query vector and a stream of
// data vectors. Send cmd=0 beats to load the query one element at a time (signed
// Q8.8), then cmd=1 beats with the data elements; every dimension_count data
// beats produce one result beat carrying the exact Q26.16 squared distance and
// the vector's number since the last query load. Any query beat restarts the
// data position, the running sum and the vector number. The block takes one
// input beat per cycle, query and data alike; the query store is a single RAM
// with one write and one registered read port, so a data beat reads its query
// element in the cycle it is accepted and a query beat writes in that same
// cycle. The beat that completes a vector passes stage 1 and stage 2; its result
// enters the four-entry output queue from stage 2 and can be taken in the next
// cycle. Input ready drops only while four results are accepted but not yet
// taken, so a slow consumer stalls the input after four finished vectors.
// Query RAM is not cleared after reset; the user must write query entries
// before data beats read them, the block does not enforce it. dimension_count
// (byte address 0) resets to 128; zero acts as one and values above
// MAX_DIMENSIONS act as MAX_DIMENSIONS. Write it only while the block is idle.

module squared_distance_engine #(
	parameter int MAX_DIMENSIONS = 1024
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// input channel
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   cmd,
	input  wire signed [sde_pkg::ELEM_W-1:0]      value,
	// result channel
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [sde_pkg::DIST_W-1:0]            distance,
	output logic [sde_pkg::VIDX_W-1:0]            vector_index,
	// configuration port
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire [sde_pkg::APB_ADDR_W-1:0]         paddr,
	input  wire [sde_pkg::APB_DATA_W-1:0]         pwdata,
	output logic [sde_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	localparam int PTR_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
	// compare width covers both the register value and MAX_DIMENSIONS itself
	localparam int CMP_W = (PTR_W + 1 > sde_pkg::DIM_CFG_W) ? PTR_W + 1 : sde_pkg::DIM_CFG_W;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [sde_pkg::DIM_CFG_W-1:0] dim_q;
	logic                          cfg_wr;
	logic                          reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == sde_pkg::REG_DIMENSION_COUNT);
	assign cfg_wr  = psel && penable && pwrite && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= sde_pkg::DIM_RESET;
		end else if (cfg_wr) begin
			dim_q <= pwdata[sde_pkg::DIM_CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = sde_pkg::APB_DATA_W'(dim_q);
		end
	end

	// Effective dimension: clamp the register to 1..MAX_DIMENSIONS
	logic [CMP_W-1:0] dim_ext;
	logic [CMP_W-1:0] eff_dim;

	always_comb begin
		dim_ext = CMP_W'(dim_q);
		if (dim_q == '0) begin
			eff_dim = CMP_W'(1);
		end else if (dim_ext > CMP_W'(MAX_DIMENSIONS)) begin
			eff_dim = CMP_W'(MAX_DIMENSIONS);
		end else begin
			eff_dim = dim_ext;
		end
	end

	// ------------------------------------------------------------------
	// Accept stage: pointers, vector number, RAM access
	// ------------------------------------------------------------------
	logic                          in_fire;
	logic                          is_query;
	logic                          is_data;
	logic [PTR_W-1:0]              query_ptr_q;
	logic [PTR_W-1:0]              data_ptr_q;
	logic [sde_pkg::VIDX_W-1:0]    vcnt_q;
	logic [CMP_W-1:0]              q_next;
	logic [CMP_W-1:0]              d_next;
	logic                          q_wrap;
	logic                          d_last;
	logic [sde_pkg::PEND_W-1:0]    pend_q;
	logic                          out_fire;

	assign in_ready = (pend_q < sde_pkg::PEND_W'(sde_pkg::FIFO_DEPTH));
	assign in_fire  = in_valid && in_ready;
	assign is_query = in_fire && (cmd == sde_pkg::CMD_QUERY);
	assign is_data  = in_fire && (cmd == sde_pkg::CMD_DATA);

	assign q_next = CMP_W'(query_ptr_q) + CMP_W'(1);
	assign d_next = CMP_W'(data_ptr_q) + CMP_W'(1);
	assign q_wrap = (q_next >= eff_dim);
	// a pointer at or past a lowered dimension still completes on this element
	assign d_last = (d_next >= eff_dim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_ptr_q <= '0;
			data_ptr_q  <= '0;
			vcnt_q      <= '0;
		end else if (is_query) begin
			query_ptr_q <= q_wrap ? '0 : q_next[PTR_W-1:0];
			data_ptr_q  <= '0;
			vcnt_q      <= '0;
		end else if (is_data) begin
			if (d_last) begin
				data_ptr_q <= '0;
				vcnt_q     <= vcnt_q + sde_pkg::VIDX_W'(1);
			end else begin
				data_ptr_q <= d_next[PTR_W-1:0];
			end
		end
	end

	// Results accepted but not yet delivered; holds off input when the queue could fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({is_data && d_last, out_fire})
				2'b10:   pend_q <= pend_q + sde_pkg::PEND_W'(1);
				2'b01:   pend_q <= pend_q - sde_pkg::PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	// Query store: written by query beats, read by data beats, never both in one cycle
	logic [sde_pkg::ELEM_W-1:0] query_rd;

	sde_ram #(
		.WIDTH (sde_pkg::ELEM_W),
		.DEPTH (MAX_DIMENSIONS)
	) u_query_ram (
		.clk   (clk),
		.we    (is_query),
		.waddr (query_ptr_q),
		.wdata (value),
		.re    (is_data),
		.raddr (data_ptr_q),
		.rdata (query_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1: query element arrives; subtract and square
	// ------------------------------------------------------------------
	logic                          v_s1;
	sde_pkg::op_t                  op_s1;
	logic                          last_s1;
	logic [sde_pkg::VIDX_W-1:0]    vidx_s1;
	logic signed [sde_pkg::ELEM_W-1:0] value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
		end
	end

	// a query beat travels down as a clear so earlier vectors finish first
	always_ff @(posedge clk) begin
		op_s1    <= (cmd == sde_pkg::CMD_DATA) ? sde_pkg::OP_DATA : sde_pkg::OP_CLEAR;
		last_s1  <= d_last;
		vidx_s1  <= vcnt_q;
		value_s1 <= value;
	end

	logic signed [sde_pkg::DIFF_W-1:0] diff_s1;
	logic signed [sde_pkg::SQ_W-1:0]   prod_s1;

	assign diff_s1 = sde_pkg::DIFF_W'(value_s1) - sde_pkg::DIFF_W'($signed(query_rd));
	assign prod_s1 = diff_s1 * diff_s1;

	// ------------------------------------------------------------------
	// Stage 2: accumulate, push finished vectors
	// ------------------------------------------------------------------
	logic                          v_s2;
	sde_pkg::op_t                  op_s2;
	logic                          last_s2;
	logic [sde_pkg::VIDX_W-1:0]    vidx_s2;
	logic [sde_pkg::SQ_W-1:0]      sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		last_s2 <= last_s1;
		vidx_s2 <= vidx_s1;
		sq_s2   <= prod_s1;
	end

	logic [sde_pkg::SUM_W-1:0] sum_q;
	logic [sde_pkg::SUM_W-1:0] sum_next;
	logic                      push;

	assign sum_next = sum_q + sde_pkg::SUM_W'(sq_s2);
	assign push     = v_s2 && (op_s2 == sde_pkg::OP_DATA) && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v_s2) begin
			if (op_s2 == sde_pkg::OP_CLEAR || last_s2) begin
				sum_q <= '0;
			end else begin
				sum_q <= sum_next;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue
	// ------------------------------------------------------------------
	sde_pkg::result_t               fifo_q [sde_pkg::FIFO_DEPTH];
	logic [sde_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [sde_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [sde_pkg::PEND_W-1:0]     fcnt_q;
	sde_pkg::result_t               head;

	assign head         = fifo_q[rd_ptr_q];
	assign out_valid    = (fcnt_q != '0);
	assign distance     = head.sq_dist;
	assign vector_index = head.vidx;
	assign out_fire     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{sq_dist: sum_next[sde_pkg::DIST_W-1:0], vidx: vidx_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sde_pkg::FIFO_PTR_W'(1);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + sde_pkg::FIFO_PTR_W'(1);
			end
			case ({push, out_fire})
				2'b10:   fcnt_q <= fcnt_q + sde_pkg::PEND_W'(1);
				2'b01:   fcnt_q <= fcnt_q - sde_pkg::PEND_W'(1);
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// queued results are always covered by the pending count
	a_fifo_le_pend: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= pend_q)
		else $error("result queue holds more than pending count");

	// a finished vector never meets a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fcnt_q < sde_pkg::PEND_W'(sde_pkg::FIFO_DEPTH)))
		else $error("result queue overflow");

	// a query beat restarts the data position and vector number
	a_query_restart: assert property (@(posedge clk) disable iff (!arst_n)
		is_query |=> (data_ptr_q == '0) && (vcnt_q == '0))
		else $error("query load did not restart data stream");

	// every beat that completes a vector gives a push once it reaches stage 2
	a_push_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(is_data && d_last) |=> ##1 push)
		else $error("completed vector lost in pipeline");

endmodule

`default_nettype wire
